[sv/wsnc_pkg.sv]
// Shared constants, types and helpers for the wall segment clip and projection core.
package wsnc_pkg;

    localparam int Z_W       = 36;
    localparam int SQ_STEPS  = 33;
    localparam int FR_STEPS  = 32;
    localparam int DIV_STEPS = 40;
    localparam int PROD_W    = 68;
    localparam int DEN_W     = 52;
    localparam int QUOT_W    = 25;

    localparam logic [QUOT_W-1:0] QCAP   = 25'h100_0000;
    localparam logic signed [Z_W-1:0] NEAR_Z = 36'sd6554;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sd1073741824;

    localparam logic [2:0] CFG_CAM_X    = 3'd0;
    localparam logic [2:0] CFG_CAM_Y    = 3'd1;
    localparam logic [2:0] CFG_CAM_COS  = 3'd2;
    localparam logic [2:0] CFG_CAM_SIN  = 3'd3;
    localparam logic [2:0] CFG_FOCAL    = 3'd4;
    localparam logic [2:0] CFG_CENTER_X = 3'd5;

    typedef struct packed {
        logic [QUOT_W-1:0] q;
        logic              rem_nz;
    } wsnc_quot_t;

    function automatic logic signed [31:0] clamp_unit(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30)
            r = ONE_Q30;
        else if (v < NEG_ONE_Q30)
            r = NEG_ONE_Q30;
        else
            r = v;
        return r;
    endfunction

endpackage

[sv/wsnc_div_lane.sv]
// Pipelined restoring divider for one projection lane, one quotient bit per stage.
module wsnc_div_lane
    import wsnc_pkg::*;
(
    input  logic              clk,
    input  logic              adv,
    input  logic [PROD_W-1:0] prod,
    input  logic [DEN_W-1:0]  den,
    output wsnc_quot_t        quot
);

    logic [PROD_W-1:0] prod_reg [0:DIV_STEPS-1];
    logic [DEN_W-1:0]  den_reg  [0:DIV_STEPS-1];
    logic [DEN_W-1:0]  rem_reg  [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] q_reg    [0:DIV_STEPS-1];

    logic [DEN_W-1:0]  rem_next [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] q_next   [0:DIV_STEPS-1];

    always_comb
    begin
        logic [PROD_W-1:0] p_in;
        logic [DEN_W-1:0]  d_in;
        logic [DEN_W-1:0]  r_in;
        logic [QUOT_W-1:0] q_in;
        logic [DEN_W:0]    rsh;
        logic              bitq;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (j == 0)
            begin
                p_in = prod;
                d_in = den;
                r_in = DEN_W'(prod[PROD_W-1:DIV_STEPS]);
                q_in = '0;
            end
            else
            begin
                p_in = prod_reg[j-1];
                d_in = den_reg[j-1];
                r_in = rem_reg[j-1];
                q_in = q_reg[j-1];
            end
            rsh = {r_in, p_in[DIV_STEPS-1-j]};
            if (rsh >= {1'b0, d_in})
            begin
                rem_next[j] = DEN_W'(rsh - {1'b0, d_in});
                bitq = 1'b1;
            end
            else
            begin
                rem_next[j] = rsh[DEN_W-1:0];
                bitq = 1'b0;
            end
            if (q_in >= QCAP)
                q_next[j] = QCAP;
            else
                q_next[j] = {q_in[QUOT_W-2:0], bitq};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= prod;
            den_reg[0]  <= den;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                prod_reg[j] <= prod_reg[j-1];
                den_reg[j]  <= den_reg[j-1];
            end
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    assign quot.q      = q_reg[DIV_STEPS-1];
    assign quot.rem_nz = |rem_reg[DIV_STEPS-1];

endmodule

[sv/wall_segment_near_clip_project_core.sv]
// Wall segment near plane clip and perspective projection core, top level.
//
// Usage: write camera registers through cfg_we/cfg_index/cfg_data while no
// request is in flight; indexes 0..5 are cam_x, cam_y, cam_cos, cam_sin,
// focal_length and screen_center_x, higher indexes are dropped.
// Segment requests enter on seg_valid/seg_stall, results leave on
// res_valid/res_stall; a request moves when valid is high and stall low.
// Throughput: one segment per cycle while res_stall does not hold the pipeline.
// Three stages form the camera transform and the squared length, 34 stages
// run the length square root beside the clip fraction divider, three stages
// clip and form the projection products, 40 stages divide by depth, and one
// stage saturates the screen columns into the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and seg_stall rises; nothing is lost or repeated.
// Reset clears all valid bits and loads the camera registers with their
// defaults; no clearing pass is needed.
module wall_segment_near_clip_project_core
    import wsnc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               seg_valid,
    output logic               seg_stall,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               visible,
    output logic signed [15:0] screen_x_start,
    output logic signed [15:0] screen_x_end,
    output logic [31:0]        depth_start,
    output logic [31:0]        depth_end,
    output logic [31:0]        tex_u_start,
    output logic [31:0]        tex_u_end
);

    typedef struct packed {
        logic        vis;
        logic        neg1;
        logic        neg2;
        logic [31:0] depth1;
        logic [31:0] depth2;
        logic [31:0] u1;
        logic [31:0] u2;
    } side_t;

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_cos_reg, cam_sin_reg;
    logic [31:0]        focal_length_reg;
    logic [11:0]        screen_center_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg           <= '0;
            cam_y_reg           <= '0;
            cam_cos_reg         <= ONE_Q30;
            cam_sin_reg         <= '0;
            focal_length_reg    <= 32'd20971520;
            screen_center_x_reg <= 12'd320;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAM_X:    cam_x_reg           <= cfg_data;
                CFG_CAM_Y:    cam_y_reg           <= cfg_data;
                CFG_CAM_COS:  cam_cos_reg         <= cfg_data;
                CFG_CAM_SIN:  cam_sin_reg         <= cfg_data;
                CFG_FOCAL:    focal_length_reg    <= cfg_data;
                CFG_CENTER_X: screen_center_x_reg <= cfg_data[11:0];
                default:      ;
            endcase
        end
    end

    logic signed [31:0] co, si;
    assign co = clamp_unit(cam_cos_reg);
    assign si = clamp_unit(cam_sin_reg);

    logic adv;
    logic res_valid_reg;
    assign adv       = !(res_valid_reg && res_stall);
    assign seg_stall = !adv;
    assign res_valid = res_valid_reg;

    // stage 1: offsets from camera and segment deltas
    logic               v1_reg;
    logic signed [32:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic [32:0]        mx_reg, my_reg;
    logic signed [32:0] ddx, ddy;

    assign ddx = 33'(end_x) - 33'(start_x);
    assign ddy = 33'(end_y) - 33'(start_y);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg <= 33'(start_x) - 33'(cam_x_reg);
            dy1_reg <= 33'(start_y) - 33'(cam_y_reg);
            dx2_reg <= 33'(end_x) - 33'(cam_x_reg);
            dy2_reg <= 33'(end_y) - 33'(cam_y_reg);
            mx_reg  <= ddx[32] ? 33'(-ddx) : ddx;
            my_reg  <= ddy[32] ? 33'(-ddy) : ddy;
        end
    end

    // stage 2: rotation products and squares
    logic               v2_reg;
    logic signed [64:0] px1c_reg, py1s_reg, py1c_reg, px1s_reg;
    logic signed [64:0] px2c_reg, py2s_reg, py2c_reg, px2s_reg;
    logic [65:0]        mx2_reg, my2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px1c_reg <= 65'(dx1_reg * co);
            py1s_reg <= 65'(dy1_reg * si);
            py1c_reg <= 65'(dy1_reg * co);
            px1s_reg <= 65'(dx1_reg * si);
            px2c_reg <= 65'(dx2_reg * co);
            py2s_reg <= 65'(dy2_reg * si);
            py2c_reg <= 65'(dy2_reg * co);
            px2s_reg <= 65'(dx2_reg * si);
            mx2_reg  <= 66'(mx_reg * mx_reg);
            my2_reg  <= 66'(my_reg * my_reg);
        end
    end

    // stage 3: camera space depth, lateral offset and squared length
    logic                  v3_reg;
    logic signed [Z_W-1:0] z1_reg, z2_reg, l1_reg, l2_reg;
    logic [65:0]           sq_reg;
    logic signed [65:0]    zs1, zs2, ls1, ls2;

    assign zs1 = 66'(px1c_reg) + 66'(py1s_reg);
    assign zs2 = 66'(px2c_reg) + 66'(py2s_reg);
    assign ls1 = 66'(py1c_reg) - 66'(px1s_reg);
    assign ls2 = 66'(py2c_reg) - 66'(px2s_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z1_reg <= zs1[65:30];
            z2_reg <= zs2[65:30];
            l1_reg <= ls1[65:30];
            l2_reg <= ls2[65:30];
            sq_reg <= mx2_reg + my2_reg;
        end
    end

    // setup: reject test and clip fraction operands
    logic               su_vis, su_first, su_clip;
    logic signed [36:0] su_num, su_den;

    always_comb
    begin
        su_vis   = !((z1_reg <= NEAR_Z) && (z2_reg <= NEAR_Z));
        su_first = z1_reg < NEAR_Z;
        su_clip  = su_vis && ((z1_reg < NEAR_Z) || (z2_reg < NEAR_Z));
        if (su_first)
        begin
            su_num = 37'(NEAR_Z) - 37'(z1_reg);
            su_den = 37'(z2_reg) - 37'(z1_reg);
        end
        else
        begin
            su_num = 37'(z1_reg) - 37'(NEAR_Z);
            su_den = 37'(z1_reg) - 37'(z2_reg);
        end
    end

    // square root and clip fraction, one bit per stage each; the fraction stops after FR_STEPS bits
    logic                  sv_reg    [0:SQ_STEPS];
    logic                  svis_reg  [0:SQ_STEPS];
    logic                  sfirst_reg[0:SQ_STEPS];
    logic                  sclip_reg [0:SQ_STEPS];
    logic signed [Z_W-1:0] sz1_reg   [0:SQ_STEPS];
    logic signed [Z_W-1:0] sz2_reg   [0:SQ_STEPS];
    logic signed [Z_W-1:0] sl1_reg   [0:SQ_STEPS];
    logic signed [Z_W-1:0] sl2_reg   [0:SQ_STEPS];
    logic [65:0]           sqv_reg   [0:SQ_STEPS];
    logic [34:0]           srem_reg  [0:SQ_STEPS];
    logic [32:0]           root_reg  [0:SQ_STEPS];
    logic [36:0]           fnum_reg  [0:SQ_STEPS];
    logic [36:0]           fden_reg  [0:SQ_STEPS];
    logic [31:0]           t_reg     [0:SQ_STEPS];

    logic [34:0] srem_next [1:SQ_STEPS];
    logic [32:0] root_next [1:SQ_STEPS];
    logic [36:0] fnum_next [1:SQ_STEPS];
    logic [31:0] t_next    [1:SQ_STEPS];

    always_comb
    begin
        logic [36:0] rsh;
        logic [36:0] trial;
        logic [37:0] fsh;
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            rsh   = {srem_reg[k-1], sqv_reg[k-1][2*(SQ_STEPS-k)+1 -: 2]};
            trial = {2'b00, root_reg[k-1], 2'b01};
            if (rsh >= trial)
            begin
                srem_next[k] = 35'(rsh - trial);
                root_next[k] = {root_reg[k-1][31:0], 1'b1};
            end
            else
            begin
                srem_next[k] = rsh[34:0];
                root_next[k] = {root_reg[k-1][31:0], 1'b0};
            end
            fsh = {fnum_reg[k-1], 1'b0};
            if (k > FR_STEPS)
            begin
                fnum_next[k] = fnum_reg[k-1];
                t_next[k]    = t_reg[k-1];
            end
            else if (fsh >= {1'b0, fden_reg[k-1]})
            begin
                fnum_next[k] = 37'(fsh - {1'b0, fden_reg[k-1]});
                t_next[k]    = {t_reg[k-1][30:0], 1'b1};
            end
            else
            begin
                fnum_next[k] = fsh[36:0];
                t_next[k]    = {t_reg[k-1][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            svis_reg[0]   <= su_vis;
            sfirst_reg[0] <= su_first;
            sclip_reg[0]  <= su_clip;
            sz1_reg[0]    <= z1_reg;
            sz2_reg[0]    <= z2_reg;
            sl1_reg[0]    <= l1_reg;
            sl2_reg[0]    <= l2_reg;
            sqv_reg[0]    <= sq_reg;
            srem_reg[0]   <= '0;
            root_reg[0]   <= '0;
            fnum_reg[0]   <= su_num;
            fden_reg[0]   <= su_den;
            t_reg[0]      <= '0;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                svis_reg[k]   <= svis_reg[k-1];
                sfirst_reg[k] <= sfirst_reg[k-1];
                sclip_reg[k]  <= sclip_reg[k-1];
                sz1_reg[k]    <= sz1_reg[k-1];
                sz2_reg[k]    <= sz2_reg[k-1];
                sl1_reg[k]    <= sl1_reg[k-1];
                sl2_reg[k]    <= sl2_reg[k-1];
                sqv_reg[k]    <= sqv_reg[k-1];
                srem_reg[k]   <= srem_next[k];
                root_reg[k]   <= root_next[k];
                fnum_reg[k]   <= fnum_next[k];
                fden_reg[k]   <= fden_reg[k-1];
                t_reg[k]      <= t_next[k];
            end
        end
    end

    // stage A: interpolation products
    logic                  va_reg;
    logic                  a_vis_reg, a_first_reg, a_clip_reg, a_dneg_reg;
    logic signed [Z_W-1:0] a_z1_reg, a_z2_reg, a_l1_reg, a_l2_reg;
    logic [26:0]           a_ulen_reg;
    logic [63:0]           a_plo_reg;
    logic [36:0]           a_phi_reg;
    logic [58:0]           a_pu_reg;
    logic signed [36:0]    dl;
    logic [36:0]           dmag;
    logic [26:0]           ulen;

    assign ulen = root_reg[SQ_STEPS][32:6];
    assign dl   = 37'(sl2_reg[SQ_STEPS]) - 37'(sl1_reg[SQ_STEPS]);
    assign dmag = dl[36] ? 37'(-dl) : dl;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_vis_reg   <= svis_reg[SQ_STEPS];
            a_first_reg <= sfirst_reg[SQ_STEPS];
            a_clip_reg  <= sclip_reg[SQ_STEPS];
            a_dneg_reg  <= dl[36];
            a_z1_reg    <= sz1_reg[SQ_STEPS];
            a_z2_reg    <= sz2_reg[SQ_STEPS];
            a_l1_reg    <= sl1_reg[SQ_STEPS];
            a_l2_reg    <= sl2_reg[SQ_STEPS];
            a_ulen_reg  <= ulen;
            a_plo_reg   <= 64'(dmag[31:0] * t_reg[SQ_STEPS]);
            a_phi_reg   <= 37'(dmag[36:32] * t_reg[SQ_STEPS]);
            a_pu_reg    <= 59'(ulen * t_reg[SQ_STEPS]);
        end
    end

    // stage B: clipped endpoint, depth clamp
    logic                  vb_reg;
    logic                  b_vis_reg, b_neg1_reg, b_neg2_reg;
    logic [Z_W-1:0]        b_m1_reg, b_m2_reg;
    logic signed [Z_W-1:0] b_z1_reg, b_z2_reg;
    logic [31:0]           b_u1_reg, b_u2_reg;
    logic [37:0]           mf;
    logic signed [38:0]    lc_w;
    logic signed [Z_W-1:0] lc, l1f, l2f;
    logic [26:0]           uc;
    logic                  clip1, clip2;

    always_comb
    begin
        mf    = 38'(a_phi_reg) + 38'(a_plo_reg[63:32]);
        if (a_dneg_reg)
            lc_w = 39'(a_l1_reg) - signed'({1'b0, mf});
        else
            lc_w = 39'(a_l1_reg) + signed'({1'b0, mf});
        lc    = lc_w[Z_W-1:0];
        uc    = a_pu_reg[58:32];
        clip1 = a_clip_reg && a_first_reg;
        clip2 = a_clip_reg && !a_first_reg;
        l1f   = clip1 ? lc : a_l1_reg;
        l2f   = clip2 ? lc : a_l2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_vis_reg  <= a_vis_reg;
            b_neg1_reg <= l1f[Z_W-1];
            b_neg2_reg <= l2f[Z_W-1];
            b_m1_reg   <= l1f[Z_W-1] ? Z_W'(-l1f) : l1f;
            b_m2_reg   <= l2f[Z_W-1] ? Z_W'(-l2f) : l2f;
            b_z1_reg   <= (a_z1_reg < NEAR_Z) ? NEAR_Z : a_z1_reg;
            b_z2_reg   <= (a_z2_reg < NEAR_Z) ? NEAR_Z : a_z2_reg;
            b_u1_reg   <= clip1 ? 32'(uc) : 32'd0;
            b_u2_reg   <= clip2 ? 32'(uc) : 32'(a_ulen_reg);
        end
    end

    // stage C: projection products and divisors
    logic              vc_reg;
    side_t             c_side_reg;
    logic [PROD_W-1:0] c_p1_reg, c_p2_reg;
    logic [DEN_W-1:0]  c_d1_reg, c_d2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg.vis    <= b_vis_reg;
            c_side_reg.neg1   <= b_neg1_reg;
            c_side_reg.neg2   <= b_neg2_reg;
            c_side_reg.depth1 <= (b_z1_reg[Z_W-1:32] != '0) ? 32'hFFFF_FFFF : b_z1_reg[31:0];
            c_side_reg.depth2 <= (b_z2_reg[Z_W-1:32] != '0) ? 32'hFFFF_FFFF : b_z2_reg[31:0];
            c_side_reg.u1     <= b_u1_reg;
            c_side_reg.u2     <= b_u2_reg;
            c_p1_reg          <= PROD_W'(b_m1_reg * focal_length_reg);
            c_p2_reg          <= PROD_W'(b_m2_reg * focal_length_reg);
            c_d1_reg          <= {b_z1_reg, 16'h0000};
            c_d2_reg          <= {b_z2_reg, 16'h0000};
        end
    end

    // depth division lanes with matching sideband delay
    wsnc_quot_t quot1, quot2;

    wsnc_div_lane u_lane1
    (
        .clk  (clk),
        .adv  (adv),
        .prod (c_p1_reg),
        .den  (c_d1_reg),
        .quot (quot1)
    );

    wsnc_div_lane u_lane2
    (
        .clk  (clk),
        .adv  (adv),
        .prod (c_p2_reg),
        .den  (c_d2_reg),
        .quot (quot2)
    );

    logic  dv_reg   [0:DIV_STEPS-1];
    side_t dside_reg[0:DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0] <= c_side_reg;
            for (int j = 1; j < DIV_STEPS; j++)
                dside_reg[j] <= dside_reg[j-1];
        end
    end

    function automatic logic signed [15:0] column(input logic [11:0] c, input wsnc_quot_t r,
                                                  input logic neg);
        logic signed [27:0] cc, mq, fl, ce, s;
        logic signed [15:0] res;
        cc = {16'h0000, c};
        mq = {3'b000, r.q};
        if (!neg)
        begin
            fl = mq;
            ce = mq + 28'(r.rem_nz);
        end
        else
        begin
            fl = -(mq + 28'(r.rem_nz));
            ce = -mq;
        end
        s = cc + fl;
        if (s < 0)
            s = cc + ce;
        if (s > 28'sd32767)
            res = 16'sh7FFF;
        else if (s < -28'sd32768)
            res = 16'sh8000;
        else
            res = s[15:0];
        return res;
    endfunction

    // output register
    side_t ds;
    assign ds = dside_reg[DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            visible <= ds.vis;
            if (ds.vis)
            begin
                screen_x_start <= column(screen_center_x_reg, quot1, ds.neg1);
                screen_x_end   <= column(screen_center_x_reg, quot2, ds.neg2);
                depth_start    <= ds.depth1;
                depth_end      <= ds.depth2;
                tex_u_start    <= ds.u1;
                tex_u_end      <= ds.u2;
            end
            else
            begin
                screen_x_start <= '0;
                screen_x_end   <= '0;
                depth_start    <= '0;
                depth_end      <= '0;
                tex_u_start    <= '0;
                tex_u_end      <= '0;
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++)
                sv_reg[k] <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            for (int j = 0; j < DIV_STEPS; j++)
                dv_reg[j] <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= seg_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sv_reg[0] <= v3_reg;
            for (int k = 1; k <= SQ_STEPS; k++)
                sv_reg[k] <= sv_reg[k-1];
            va_reg    <= sv_reg[SQ_STEPS];
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            dv_reg[0] <= vc_reg;
            for (int j = 1; j < DIV_STEPS; j++)
                dv_reg[j] <= dv_reg[j-1];
            res_valid_reg <= dv_reg[DIV_STEPS-1];
        end
    end

endmodule

[sim/tb_wall_segment_near_clip_project_core.sv]
// Testbench for the wall segment near plane clip and projection core.
`timescale 1ns / 100ps

module tb_wall_segment_near_clip_project_core;
    import wsnc_pkg::*;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] sx_start;
        logic signed [15:0] sx_end;
        logic [31:0]        z_start;
        logic [31:0]        z_end;
        logic [31:0]        u_start;
        logic [31:0]        u_end;
    } wall_view_t;

    localparam int LATENCY = 81;
    localparam logic signed [127:0] NEAR_W = NEAR_Z;
    localparam logic [127:0] M32 = 128'hFFFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               seg_valid;
    logic               seg_stall;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               res_valid;
    logic               res_stall;
    logic               visible;
    logic signed [15:0] screen_x_start;
    logic signed [15:0] screen_x_end;
    logic [31:0]        depth_start;
    logic [31:0]        depth_end;
    logic [31:0]        tex_u_start;
    logic [31:0]        tex_u_end;

    logic signed [31:0] view_x, view_y, view_cos, view_sin;
    logic [31:0]        view_focal;
    logic [11:0]        view_center;

    wall_view_t pending_views[$];
    int  error_count;
    int  segments_sent;
    int  views_checked;
    int  rejected_seen;
    int  config_writes;
    bit  steady;

    wall_segment_near_clip_project_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .seg_valid(seg_valid), .seg_stall(seg_stall),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .res_valid(res_valid), .res_stall(res_stall),
        .visible(visible), .screen_x_start(screen_x_start), .screen_x_end(screen_x_end),
        .depth_start(depth_start), .depth_end(depth_end),
        .tex_u_start(tex_u_start), .tex_u_end(tex_u_end)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [127:0] isqrt_wide(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] b;
        r = 0;
        b = 128'd1 << 126;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] screen_column(input logic signed [127:0] lat,
                                                          input logic signed [127:0] z);
        logic signed [127:0] mag, prod, den, q, rm, fl, ce, s, c;
        mag  = (lat < 0) ? -lat : lat;
        prod = mag * $signed({96'b0, view_focal});
        den  = z <<< 16;
        q    = prod / den;
        rm   = prod % den;
        c    = $signed({116'b0, view_center});
        if (lat >= 0)
        begin
            fl = q;
            ce = q + ((rm != 0) ? 1 : 0);
        end
        else
        begin
            fl = -(q + ((rm != 0) ? 1 : 0));
            ce = -q;
        end
        s = c + fl;
        if (s < 0)
            s = c + ce;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s[15:0];
    endfunction

    function automatic wall_view_t project_wall(input logic signed [31:0] x1, y1, x2, y2);
        wall_view_t v;
        logic signed [127:0] co, si, dx1, dy1, dx2, dy2, ex, ey;
        logic signed [127:0] z1, z2, l1, l2, d, lc, num, den;
        logic [127:0] tlen, frac, u1, u2;
        co = (view_cos > ONE_Q30) ? ONE_Q30 : (view_cos < NEG_ONE_Q30) ? NEG_ONE_Q30 : view_cos;
        si = (view_sin > ONE_Q30) ? ONE_Q30 : (view_sin < NEG_ONE_Q30) ? NEG_ONE_Q30 : view_sin;
        dx1 = 128'(x1) - 128'(view_x);
        dy1 = 128'(y1) - 128'(view_y);
        dx2 = 128'(x2) - 128'(view_x);
        dy2 = 128'(y2) - 128'(view_y);
        ex = 128'(x2) - 128'(x1);
        ey = 128'(y2) - 128'(y1);
        tlen = isqrt_wide(ex * ex + ey * ey) >> 6;
        u1 = 0;
        u2 = tlen;
        z1 = (dx1 * co + dy1 * si) >>> 30;
        z2 = (dx2 * co + dy2 * si) >>> 30;
        l1 = (dy1 * co - dx1 * si) >>> 30;
        l2 = (dy2 * co - dx2 * si) >>> 30;
        v = '0;
        if (z1 <= NEAR_W && z2 <= NEAR_W)
            return v;
        if (z1 < NEAR_W || z2 < NEAR_W)
        begin
            num  = NEAR_W - z1;
            den  = z2 - z1;
            num  = (num < 0) ? -num : num;
            den  = (den < 0) ? -den : den;
            frac = (num <<< 32) / den;
            d = l2 - l1;
            if (d >= 0)
                lc = l1 + $signed((d * $signed(frac)) >> 32);
            else
                lc = l1 - $signed(((-d) * $signed(frac)) >> 32);
            if (z1 < NEAR_W)
            begin
                l1 = lc;
                u1 = (tlen * frac) >> 32;
            end
            else
            begin
                l2 = lc;
                u2 = (tlen * frac) >> 32;
            end
        end
        if (z1 < NEAR_W)
            z1 = NEAR_W;
        if (z2 < NEAR_W)
            z2 = NEAR_W;
        v.visible  = 1'b1;
        v.sx_start = screen_column(l1, z1);
        v.sx_end   = screen_column(l2, z2);
        v.z_start  = (z1 > $signed(M32)) ? 32'hFFFF_FFFF : z1[31:0];
        v.z_end    = (z2 > $signed(M32)) ? 32'hFFFF_FFFF : z2[31:0];
        v.u_start  = u1[31:0];
        v.u_end    = u2[31:0];
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= (pick_gap() != 0);
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        wall_view_t w;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_views.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual visible=%b", $time,
                         visible);
            end
            else
            begin
                w = pending_views.pop_front();
                compare_field("visible", w.visible, visible);
                compare_field("screen_x_start", 32'(w.sx_start), 32'(screen_x_start));
                compare_field("screen_x_end", 32'(w.sx_end), 32'(screen_x_end));
                compare_field("depth_start", w.z_start, depth_start);
                compare_field("depth_end", w.z_end, depth_end);
                compare_field("tex_u_start", w.u_start, tex_u_start);
                compare_field("tex_u_end", w.u_end, tex_u_end);
                views_checked++;
                if (!w.visible)
                    rejected_seen++;
            end
        end
    end

    task automatic drain();
        @(negedge clk);
        seg_valid = 1'b0;
        wait (pending_views.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        case (idx)
            CFG_CAM_X:    view_x = data;
            CFG_CAM_Y:    view_y = data;
            CFG_CAM_COS:  view_cos = data;
            CFG_CAM_SIN:  view_sin = data;
            CFG_FOCAL:    view_focal = data;
            CFG_CENTER_X: view_center = data[11:0];
            default:      ;
        endcase
        config_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_camera(input logic [31:0] x, y, c, s, f, input logic [11:0] cx);
        write_reg(CFG_CAM_X, x);
        write_reg(CFG_CAM_Y, y);
        write_reg(CFG_CAM_COS, c);
        write_reg(CFG_CAM_SIN, s);
        write_reg(CFG_FOCAL, f);
        write_reg(CFG_CENTER_X, {20'b0, cx});
    endtask

    task automatic send_segment(input logic signed [31:0] x1, y1, x2, y2);
        int gap;
        @(negedge clk);
        seg_valid = 1'b1;
        start_x   = x1;
        start_y   = y1;
        end_x     = x2;
        end_y     = y2;
        do
            @(posedge clk);
        while (seg_stall);
        pending_views.push_back(project_wall(x1, y1, x2, y2));
        segments_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            seg_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic signed [31:0] near_coord(input logic signed [31:0] base);
        logic signed [63:0] span;
        logic signed [63:0] off;
        case ($urandom_range(0, 3))
            0:       span = 64'd65536;
            1:       span = 64'd1 << 20;
            2:       span = 64'd1 << 24;
            default: span = 64'd1 << 28;
        endcase
        off = $signed(64'($urandom_range(0, 32'(2 * span)))) - span;
        return base + off[31:0];
    endfunction

    task automatic test_defaults();
        steady = 1'b1;
        send_segment(32'sd65536, 32'sd0, 32'sd131072, 32'sd327680);
        send_segment(-32'sd65536, 32'sd0, -32'sd131072, 32'sd65536);
        send_segment(32'sd6554, 32'sd6554, 32'sd6554, -32'sd6554);
        send_segment(32'sd6554, 32'sd65536, 32'sd655360, -32'sd65536);
        send_segment(-32'sd65536, 32'sd65536, 32'sd327680, -32'sd196608);
        send_segment(32'sd327680, -32'sd196608, -32'sd65536, 32'sd65536);
        send_segment(32'sd6555, 32'sh7FFF_FFFF, 32'sd6555, 32'sh8000_0000);
        send_segment(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        send_segment(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_segment(32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFF, 32'sd0);
        send_segment(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_segment(32'sd6553, 32'sd100, 32'sd6556, -32'sd100);
        steady = 1'b0;
    endtask

    task automatic test_camera_extremes();
        set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000, 32'h0, 32'hFFFF_FFFF, 12'd4095);
        send_segment(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_segment(32'sh7FFF_FFFF, 32'sd0, 32'sh8000_0000, 32'sd0);
        set_camera(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 12'd0);
        send_segment(32'sd655360, -32'sd655360, 32'sd65536, 32'sd65536);
        send_segment(-32'sd655360, 32'sd655360, 32'sd65536, -32'sd65536);
        set_camera(32'h0, 32'h0, 32'hC000_0000, 32'h4000_0000, 32'd1, 12'd2048);
        send_segment(-32'sd655360, 32'sd0, 32'sd655360, 32'sd655360);
        send_segment(32'sd0, 32'sd655360, 32'sd0, -32'sd655360);
        write_reg(3'd6, 32'hDEAD_BEEF);
        write_reg(3'd7, 32'h1234_5678);
        send_segment(-32'sd655360, 32'sd0, -32'sd65536, 32'sd0);
    endtask

    task automatic test_random_segments();
        logic signed [31:0] x1, y1, x2, y2;
        for (int i = 0; i < 550; i++)
        begin
            if (i % 110 == 0)
                set_camera(($urandom_range(0, 3) == 0) ? $urandom : near_coord(0),
                           ($urandom_range(0, 3) == 0) ? $urandom : near_coord(0),
                           ($urandom_range(0, 4) == 0) ? $urandom
                               : 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000,
                           ($urandom_range(0, 4) == 0) ? $urandom
                               : 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000,
                           ($urandom_range(0, 5) == 0) ? $urandom
                               : 32'($urandom_range(32'h0001_0000, 32'h0400_0000)),
                           12'($urandom_range(0, 4095)));
            if (i % 137 == 70)
                steady = ~steady;
            if ($urandom_range(0, 9) < 7)
            begin
                x1 = near_coord(view_x);
                y1 = near_coord(view_y);
                x2 = near_coord(view_x);
                y2 = near_coord(view_y);
            end
            else
            begin
                x1 = $urandom;
                y1 = $urandom;
                x2 = $urandom;
                y2 = $urandom;
            end
            send_segment(x1, y1, x2, y2);
        end
        steady = 1'b0;
    endtask

    task automatic test_pause_until_idle();
        @(negedge clk);
        seg_valid = 1'b0;
        wait (pending_views.size() == 0);
        for (int i = 0; i < 12; i++)
            send_segment(near_coord(view_x), near_coord(view_y),
                         near_coord(view_x), near_coord(view_y));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        seg_valid  = 1'b0;
        start_x    = '0;
        start_y    = '0;
        end_x      = '0;
        end_y      = '0;
        view_x     = 0;
        view_y     = 0;
        view_cos   = ONE_Q30;
        view_sin   = 0;
        view_focal = 32'd20971520;
        view_center = 12'd320;
        error_count = 0;
        segments_sent = 0;
        views_checked = 0;
        rejected_seen = 0;
        config_writes = 0;
        steady = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_camera_extremes();
        test_pause_until_idle();
        test_random_segments();

        @(negedge clk);
        seg_valid = 1'b0;
        wait (pending_views.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        $display("Covered %0d segments (%0d rejected) over %0d register writes.",
                 segments_sent, rejected_seen, config_writes);
        $display("Checked %0d results with random stalls on both channels.", views_checked);
        if (error_count == 0 && pending_views.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", pending_views.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
